/* rtl/shabsh_pkg.sv */
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
// No dependencies; imported by the top level, buffer and round modules.
package shabsh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [0:7][31:0] state8_t;
  typedef logic [0:15][31:0] window_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       sched;
    logic [5:0] rnd;
  } rnd_ctrl_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenBoundary = 56;
  localparam logic [7:0] PadByte = 8'h80;

  localparam state8_t InitChain = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t bsig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* rtl/sha256_byte_stream_hasher.sv */
// SHA-256 byte stream hasher, top level: sequencer, padding, chaining state.
// Depends on shabsh_pkg, shabsh_buffer, shabsh_round.
//
// Usage: the message enters one byte per transfer on the item channel
// (item_valid/item_ready; data_byte, has_byte, final_item). An item without
// has_byte carries no byte; with final_item it ends the message, so an empty
// message is one empty final item. The digest leaves on the digest channel
// (digest_valid/digest_ready) as eight transfers of 32-bit words, word 0
// first, last_word set on word 7.
// Flow: a byte that does not complete a 64-byte block is accepted without
// starting a block. Each block runs one round per cycle through the shared
// round unit: a load, 64 rounds and a chaining add, all with item_ready low.
// A final item costs one block, or two when fewer than 9 bytes of the block
// remain, plus a full block first if its byte completes one. The digest
// words then hold until taken; a stalled receiver holds the block in the
// output phase with item_ready low. After word 7 is taken the block returns
// to the initial chaining state.
// Reset (rst, synchronous) loads the initial hash values and clears counts.
module sha256_byte_stream_hasher
  import shabsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        final_item,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  seq_state_t state;
  seq_state_t state_next;

  state8_t     chain;
  state8_t     vars;
  logic [5:0]  fill;
  logic [63:0] bitcnt;
  logic [5:0]  rnd;
  logic [2:0]  widx;
  logic [6:0]  blk_len;
  logic        blk_pad;
  logic        blk_lenf;
  logic        more;
  logic        more_pad;
  logic        fin;

  logic [6:0]  n7;
  logic [5:0]  m;
  logic        full;
  logic        wr_en;
  logic [3:0]  rd_addr;
  word_t       rd_word;
  word_t       msg_word;
  rnd_ctrl_t   ctrl;
  logic [6:0]  pos;

  assign n7   = {1'b0, fill} + 7'd1;
  assign full = has_byte && (n7 == 7'(BlockBytes));
  assign m    = has_byte ? n7[5:0] : fill;

  shabsh_buffer u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill),
    .wr_byte (data_byte),
    .rd_addr (rd_addr),
    .rd_word (rd_word)
  );

  shabsh_round u_round (
    .clk      (clk),
    .ctrl     (ctrl),
    .chain    (chain),
    .msg_word (msg_word),
    .vars     (vars)
  );

  // padded message word for rounds 0..15
  always_comb begin
    msg_word = '0;
    pos      = '0;
    for (int j = 0; j < 4; j++) begin
      pos = {1'b0, rnd[3:0], 2'(j)};
      if (pos < blk_len) begin
        msg_word[8*(3-j) +: 8] = rd_word[8*(3-j) +: 8];
      end else if (blk_pad && (pos == blk_len)) begin
        msg_word[8*(3-j) +: 8] = PadByte;
      end
    end
    if (blk_lenf && (rnd[3:0] == 4'd14)) begin
      msg_word = bitcnt[63:32];
    end else if (blk_lenf && (rnd[3:0] == 4'd15)) begin
      msg_word = bitcnt[31:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && (full || final_item)) state_next = ST_INIT;
      end
      ST_INIT:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (rnd == 6'd63) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (more) state_next = ST_INIT;
        else if (fin) state_next = ST_EMIT;
        else state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (digest_ready && (widx == 3'd7)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready   = 1'b0;
    digest_valid = 1'b0;
    wr_en        = 1'b0;
    rd_addr      = '0;
    ctrl         = '{load: 1'b0, step: 1'b0, sched: |rnd[5:4], rnd: rnd};
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        wr_en      = item_valid && has_byte;
      end
      ST_INIT:  ctrl.load = 1'b1;
      ST_ROUND: begin
        ctrl.step = 1'b1;
        rd_addr   = rnd[3:0] + 4'd1;
      end
      ST_EMIT:  digest_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      chain  <= InitChain;
      fill   <= '0;
      bitcnt <= '0;
      rnd    <= '0;
      widx   <= '0;
      more   <= 1'b0;
      fin    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (has_byte) bitcnt <= bitcnt + 64'd8;
            fin <= final_item;
            if (full) begin
              fill     <= '0;
              blk_len  <= 7'(BlockBytes);
              blk_pad  <= 1'b0;
              blk_lenf <= 1'b0;
              more     <= final_item;
              more_pad <= 1'b1;
            end else begin
              fill     <= m;
              blk_len  <= {1'b0, m};
              blk_pad  <= 1'b1;
              more_pad <= 1'b0;
              if (m < 6'(LenBoundary)) begin
                blk_lenf <= 1'b1;
                more     <= 1'b0;
              end else begin
                blk_lenf <= 1'b0;
                more     <= final_item;
              end
            end
          end
        end
        ST_INIT:  rnd <= '0;
        ST_ROUND: rnd <= rnd + 6'd1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          widx <= '0;
          if (more) begin
            blk_len  <= '0;
            blk_pad  <= more_pad;
            blk_lenf <= 1'b1;
            more     <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (digest_ready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              chain  <= InitChain;
              fill   <= '0;
              bitcnt <= '0;
              fin    <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign digest_word = chain[widx];
  assign word_index  = widx;
  assign last_word   = (widx == 3'd7);

endmodule

/* rtl/shabsh_buffer.sv */
// Block buffer: 16 x 32-bit words, byte-lane write, registered word read.
// Depends on shabsh_pkg.
module shabsh_buffer
  import shabsh_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  logic [5:0] wr_addr,
  input  logic [7:0] wr_byte,
  input  logic [3:0] rd_addr,
  output word_t      rd_word
);

  logic [31:0] mem [16];

  // byte 0 of a word sits in bits 31..24
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    rd_word <= mem[rd_addr];
  end

endmodule

/* rtl/shabsh_round.sv */
// Shared compression round unit: working variables, message schedule window,
// one SHA-256 round per step. Depends on shabsh_pkg.
module shabsh_round
  import shabsh_pkg::*;
(
  input  logic      clk,
  input  rnd_ctrl_t ctrl,
  input  state8_t   chain,
  input  word_t     msg_word,
  output state8_t   vars
);

  window_t win;
  state8_t wv;
  word_t   w;
  word_t   t1;
  word_t   t2;
  word_t   ch;
  word_t   maj;

  always_comb begin
    w   = ctrl.sched ? (ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0]) : msg_word;
    ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1  = wv[7] + bsig1(wv[4]) + ch + RoundK[ctrl.rnd] + w;
    t2  = bsig0(wv[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      wv <= chain;
    end else if (ctrl.step) begin
      wv  <= {t1 + t2, wv[0], wv[1], wv[2], wv[3] + t1, wv[4], wv[5], wv[6]};
      win <= {win[1:15], w};
    end
  end

  assign vars = wv;

endmodule

/* rtl/shabsh_checker.sv */
// Port-level checks of the SHA-256 byte stream hasher, bound to the top level.
// Depends on sha256_byte_stream_hasher ports only.
module shabsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        digest_valid,
  input logic        digest_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && digest_valid))
    else $error("item_ready high during digest output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest_word)
      && $stable(word_index))
    else $error("digest word changed while stalled");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !last_word |=>
      digest_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words not contiguous");

  a_start_idx: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> (word_index == 3'd0))
    else $error("digest does not start at word 0");

endmodule

bind sha256_byte_stream_hasher shabsh_checker u_shabsh_checker (.*);
